### src/toac_pkg.sv
// Shared command and status types for the tile overlap agreement check.
package toac_pkg;

   typedef struct packed {
      logic capture;
      logic mem_write;
      logic mem_read;
      logic load_result;
   } toac_cmd_type;

   typedef struct packed {
      logic op_is_check;
   } toac_status_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

endpackage

### src/toac_ctrl.sv
// Controller state machine that sequences tile writes, checks and result handoff.
module toac_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output toac_pkg::toac_cmd_type   cmd,
   input  toac_pkg::toac_status_type status
);
   import toac_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      cmd              = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_CHECK) ? S_READ : S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (status.op_is_check && rsp_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (!status.op_is_check) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/toac_datapath.sv
// Datapath with the tile memory, input registers and the masked overlap compare.
module toac_datapath #(
   parameter int TILE_SIZE  = 3,
   parameter int MAX_TILES  = 256,
   parameter int INDEX_BITS = 8
) (
   input  logic                      clock,
   input  toac_pkg::toac_cmd_type    cmd,
   output toac_pkg::toac_status_type status,
   input  logic                      req_op,
   input  logic [7:0]                req_tile_a,
   input  logic [7:0]                req_tile_b,
   input  logic [1:0]                req_cell_x,
   input  logic [1:0]                req_cell_y,
   input  logic [7:0]                req_cell_value,
   input  logic signed [2:0]         req_offset_x,
   input  logic signed [2:0]         req_offset_y,
   output logic                      rsp_agree
);
   import toac_pkg::*;

   localparam int CELLS     = TILE_SIZE * TILE_SIZE;
   localparam int WORD_BITS = CELLS * INDEX_BITS;
   localparam int TILE_BITS = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CELL_BITS = $clog2(CELLS);

   function automatic logic [TILE_BITS-1:0] tile_mod(input logic [7:0] tile);
      int r;
      r = int'(tile);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (MAX_TILES << k)) begin
            r = r - (MAX_TILES << k);
         end
      end
      return TILE_BITS'(r);
   endfunction

   logic [WORD_BITS-1:0]  mem [MAX_TILES];

   logic                  op_ff;
   logic [TILE_BITS-1:0]  ta_ff;
   logic [TILE_BITS-1:0]  tb_ff;
   logic [CELL_BITS-1:0]  cell_ff;
   logic                  cell_ok_ff;
   logic [INDEX_BITS-1:0] value_ff;
   logic signed [2:0]     dx_ff;
   logic signed [2:0]     dy_ff;
   logic [WORD_BITS-1:0]  word_a_ff;
   logic [WORD_BITS-1:0]  word_b_ff;
   logic                  agree_ff, agree_in;
   logic [15:0]           value_wide;

   assign value_wide = {8'b0, req_cell_value};
   assign status.op_is_check = op_ff;
   assign rsp_agree = agree_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         ta_ff      <= tile_mod(req_tile_a);
         tb_ff      <= tile_mod(req_tile_b);
         cell_ff    <= CELL_BITS'(int'(req_cell_x) * TILE_SIZE + int'(req_cell_y));
         cell_ok_ff <= (int'(req_cell_x) < TILE_SIZE) && (int'(req_cell_y) < TILE_SIZE);
         value_ff   <= value_wide[INDEX_BITS-1:0];
         dx_ff      <= req_offset_x;
         dy_ff      <= req_offset_y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && cell_ok_ff) begin
         mem[ta_ff][cell_ff*INDEX_BITS +: INDEX_BITS] <= value_ff;
      end
      if (cmd.mem_read) begin
         word_a_ff <= mem[ta_ff];
         word_b_ff <= mem[tb_ff];
      end
   end

   always_comb begin
      logic signed [3:0]    bx;
      logic signed [3:0]    by;
      logic [CELL_BITS-1:0] b_cell;
      agree_in = 1'b1;
      for (int x = 0; x < TILE_SIZE; x++) begin
         for (int y = 0; y < TILE_SIZE; y++) begin
            bx = 4'(x) - {dx_ff[2], dx_ff};
            by = 4'(y) - {dy_ff[2], dy_ff};
            b_cell = CELL_BITS'(int'(bx[1:0]) * TILE_SIZE + int'(by[1:0]));
            if (bx >= 0 && bx < 4'(TILE_SIZE) && by >= 0 && by < 4'(TILE_SIZE)) begin
               if (word_a_ff[(x*TILE_SIZE+y)*INDEX_BITS +: INDEX_BITS]
                   != word_b_ff[b_cell*INDEX_BITS +: INDEX_BITS]) begin
                  agree_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         agree_ff <= agree_in;
      end
   end

endmodule

### src/tile_overlap_agreement_check_top.sv
// Top level of the tile overlap agreement check.
//
// The req channel carries one item per handshake. A write item (op low) stores
// one palette index into one cell of one tile and returns nothing. A check item
// (op high) compares tile A against tile B shifted by the signed offset and
// returns one rsp item whose agree bit is high when every overlapping cell
// matches. Each tile is one memory word, so a check reads both tiles in the same
// cycle through two read ports of the tile memory.
// A write steps through capture and memory write, then back to idle. A check
// steps through capture, memory read, compare; the result appears on rsp in the
// cycle after the compare state. One item is in work at a time.
// The result sits in an output register, so the block accepts the next item
// while a result waits. If the receiver stalls, a following check holds in
// its compare state until the output register frees; writes still complete.
// Reset clears the controller and the rsp valid flag. The tile memory is not
// cleared; a cell reads as undefined until written.
module tile_overlap_agreement_check_top #(
   parameter int TILE_SIZE  = 3,
   parameter int MAX_TILES  = 256,
   parameter int INDEX_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [7:0]        req_tile_a,
   input  logic [7:0]        req_tile_b,
   input  logic [1:0]        req_cell_x,
   input  logic [1:0]        req_cell_y,
   input  logic [7:0]        req_cell_value,
   input  logic signed [2:0] req_offset_x,
   input  logic signed [2:0] req_offset_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_agree
);
   import toac_pkg::*;

   toac_cmd_type    cmd;
   toac_status_type status;

   toac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   toac_datapath #(
      .TILE_SIZE  (TILE_SIZE),
      .MAX_TILES  (MAX_TILES),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_tile_a     (req_tile_a),
      .req_tile_b     (req_tile_b),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_value (req_cell_value),
      .req_offset_x   (req_offset_x),
      .req_offset_y   (req_offset_y),
      .rsp_agree      (rsp_agree)
   );

endmodule
